>>> src/aispe_pkg.sv
// ----------------------------------------------------------------------------
// aispe_pkg
// Constants and helpers shared by the AIS position report encoder.
// ----------------------------------------------------------------------------
package aispe_pkg;

  localparam int CHAR_W       = 8;
  localparam int SIX_W        = 6;
  localparam int PAYLOAD_BITS = 168;
  localparam int NUM_CELLS    = 28;
  localparam int IDX_W        = 6;
  localparam int IN_W         = 144;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SIX_W-1:0]  six_t;

  localparam idx_t IDX_FIRST    = 6'd0;
  localparam idx_t IDX_TALKER_1 = 6'd1;
  localparam idx_t IDX_TALKER_2 = 6'd2;
  localparam idx_t IDX_PAY_LO   = 6'd14;
  localparam idx_t IDX_PAY_HI   = 6'd41;
  localparam idx_t IDX_SUM_HI   = 6'd43;
  localparam idx_t IDX_HEX_HI   = 6'd45;
  localparam idx_t IDX_HEX_LO   = 6'd46;
  localparam idx_t IDX_LAST     = 6'd48;

  localparam char_t CHAR_LF = 8'h0A;
  localparam char_t CHAR_CR = 8'h0D;

  localparam logic [CHAR_W-1:0] TALKER_1_RST = 8'd65;
  localparam logic [CHAR_W-1:0] TALKER_2_RST = 8'd73;

  // six-bit payload armoring
  function automatic char_t armor(input six_t v);
    char_t w;
    w = {2'b00, v};
    return (v < 6'd40) ? char_t'(w + 8'd48) : char_t'(w + 8'd56);
  endfunction

  function automatic char_t hex_char(input logic [3:0] n);
    char_t w;
    w = {4'h0, n};
    return (n < 4'd10) ? char_t'(w + 8'h30) : char_t'(w + 8'h37);
  endfunction

  // fixed characters of the sentence frame
  function automatic char_t frame_char(input idx_t idx);
    char_t c;
    case (idx)
      6'd0:    c = "!";
      6'd3:    c = "V";
      6'd4:    c = "D";
      6'd5:    c = "M";
      6'd6:    c = ",";
      6'd7:    c = "1";
      6'd8:    c = ",";
      6'd9:    c = "1";
      6'd10:   c = ",";
      6'd11:   c = ",";
      6'd12:   c = "A";
      6'd13:   c = ",";
      6'd42:   c = ",";
      6'd43:   c = "2";
      6'd44:   c = "*";
      6'd47:   c = CHAR_CR;
      6'd48:   c = CHAR_LF;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> src/ais_position_report_encoder_core.sv
// ----------------------------------------------------------------------------
// ais_position_report_encoder_core
// AIS message 1 position report to NMEA VDM sentence encoder.
//
// Input stream (s_*): one pre-scaled report per transaction. Output stream
// (m_*): the 49-byte sentence "!ttVDM,1,1,,A,<28 chars>,2*HH" CR LF, one
// ASCII byte per transaction, tlast on the final line feed.
// The 168-bit report is loaded into a row of 28 six-bit cells that shift
// toward the head as payload characters go out; the XOR checksum is
// accumulated from the bytes as they pass.
// Accepting a report sets the sequencer active, which then registers the
// first byte into the output register; bytes go out one per cycle while
// the receiver does not stall. The next report is accepted in the cycle
// the line feed is registered, so sentences follow without gaps.
// When the receiver stalls, the output register holds and the sequencer
// waits. Reset clears the stream control and sets the talker to "AI".
// APB: talker byte 1 at 0x0, talker byte 2 at 0x4.
// ----------------------------------------------------------------------------
module ais_position_report_encoder_core (
  input  logic                     clk,
  input  logic                     rst,
  // tdata: msg_kind[5:0], vessel_mmsi[35:6], status_code[39:36],
  //        turn_rate[47:40], ground_speed[57:48], pos_accuracy[58],
  //        longitude_pos[86:59], latitude_pos[113:87], ground_course[125:114],
  //        utc_second[131:126], utc_hour[136:132], utc_minute[143:137]
  input  logic [aispe_pkg::IN_W-1:0] s_tdata,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // tdata: sentence_char[7:0]; tlast: last_char
  output aispe_pkg::char_t         m_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic                     m_tlast,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import aispe_pkg::*;

  char_t talker_1;
  char_t talker_2;
  char_t sum;
  idx_t  idx;
  logic  active;

  logic  advance;
  logic  accept;
  logic  shift;
  char_t cur_byte;
  logic [PAYLOAD_BITS-1:0] packed_bits;
  six_t  cell_val [NUM_CELLS];

  assign pready = 1'b1;
  assign prdata = {24'h000000, paddr[2] ? talker_2 : talker_1};

  always_ff @(posedge clk) begin
    if (rst) begin
      talker_1 <= TALKER_1_RST;
      talker_2 <= TALKER_2_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        talker_2 <= pwdata[7:0];
      end else begin
        talker_1 <= pwdata[7:0];
      end
    end
  end

  assign packed_bits = {s_tdata[5:0], 2'b00, s_tdata[35:6], s_tdata[39:36],
                        s_tdata[47:40], s_tdata[57:48], s_tdata[58],
                        s_tdata[86:59], s_tdata[113:87], s_tdata[125:114],
                        9'h1FF, s_tdata[131:126], 2'b00, 3'b000, 1'b0, 2'b00,
                        3'b001, s_tdata[136:132], s_tdata[143:137], 2'b00};

  assign advance  = active && (!m_tvalid || m_tready);
  assign s_tready = !active || (advance && (idx == IDX_LAST));
  assign accept   = s_tvalid && s_tready;
  assign shift    = advance && (idx inside {[IDX_PAY_LO:IDX_PAY_HI]});

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    six_t nxt;
    if (i == NUM_CELLS - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cell_val[i+1];
    end
    aispe_cell u_cell (
      .clk      (clk),
      .load     (accept),
      .shift    (shift),
      .load_val (packed_bits[PAYLOAD_BITS-1-SIX_W*i -: SIX_W]),
      .next_val (nxt),
      .val      (cell_val[i])
    );
  end

  always_comb begin
    if (idx inside {[IDX_PAY_LO:IDX_PAY_HI]}) begin
      cur_byte = armor(cell_val[0]);
    end else begin
      case (idx)
        IDX_TALKER_1: cur_byte = talker_1;
        IDX_TALKER_2: cur_byte = talker_2;
        IDX_HEX_HI:   cur_byte = hex_char(sum[7:4]);
        IDX_HEX_LO:   cur_byte = hex_char(sum[3:0]);
        default:      cur_byte = frame_char(idx);
      endcase
    end
  end

  // idx wraps to the first byte at the end of a sentence and rests there
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
      idx      <= IDX_FIRST;
    end else begin
      if (advance) begin
        m_tvalid <= 1'b1;
        m_tdata  <= cur_byte;
        m_tlast  <= (idx == IDX_LAST);
        idx      <= (idx == IDX_LAST) ? IDX_FIRST : idx_t'(idx + 6'd1);
        if (idx == IDX_FIRST) begin
          sum <= '0;
        end else if (idx <= IDX_SUM_HI) begin
          sum <= sum ^ cur_byte;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        active <= 1'b1;
      end else if (advance && (idx == IDX_LAST)) begin
        active <= 1'b0;
      end
    end
  end

  a_last_is_lf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == CHAR_LF)
    else $error("tlast on a byte other than line feed");

  a_accept_at_end: assert property (@(posedge clk) disable iff (rst)
    accept && active |-> advance && idx == IDX_LAST)
    else $error("report accepted in the middle of a sentence");

  a_start_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> active && idx == IDX_FIRST)
    else $error("sequencer did not restart after accept");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    active |-> idx <= IDX_LAST)
    else $error("byte index beyond sentence length");

  a_tlast_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !active || idx == IDX_FIRST)
    else $error("sequencer still running after final byte");

endmodule

>>> src/aispe_cell.sv
// ----------------------------------------------------------------------------
// aispe_cell
// One six-bit payload cell; loads a packed symbol or takes its neighbor's.
// ----------------------------------------------------------------------------
module aispe_cell (
  input  logic              clk,
  input  logic              load,
  input  logic              shift,
  input  aispe_pkg::six_t   load_val,
  input  aispe_pkg::six_t   next_val,
  output aispe_pkg::six_t   val
);
  import aispe_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      val <= load_val;
    end else if (shift) begin
      val <= next_val;
    end
  end

endmodule

>>> tb/sv/tb_ais_position_report_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ais_position_report_encoder_core
// Self-checking bench for the AIS position report to VDM sentence encoder.
// Reports go in through a bursty stream driver. Each accepted report is
// packed and armored by the bench's own encoder into the 49 bytes of its
// sentence. A monitor compares every output byte and tlast against them
// while the receiver stalls on its own pattern. The talker bytes are
// rewritten over APB between phases, including the byte extremes.
// ----------------------------------------------------------------------------
module tb_ais_position_report_encoder_core;
  import aispe_pkg::*;

  localparam logic [2:0] REG_TALKER_FIRST  = 3'h0;
  localparam logic [2:0] REG_TALKER_SECOND = 3'h4;
  localparam int         SENTENCE_BYTES    = 49;
  localparam int         IDLE_LIMIT        = 3000;
  localparam int         RANDOM_PER_PHASE  = 55;
  localparam int         NUM_PHASES        = 6;
  localparam logic [87:0] VDM_HEAD         = "VDM,1,1,,A,";

  // raw field bits, two's complement for turn rate, longitude and latitude
  typedef struct packed {
    logic [6:0]  utc_minute;
    logic [4:0]  utc_hour;
    logic [5:0]  utc_second;
    logic [11:0] ground_course;
    logic [26:0] latitude_pos;
    logic [27:0] longitude_pos;
    logic        pos_accuracy;
    logic [9:0]  ground_speed;
    logic [7:0]  turn_rate;
    logic [3:0]  status_code;
    logic [29:0] vessel_mmsi;
    logic [5:0]  msg_kind;
  } report_t;

  typedef struct {
    char_t       ch;
    logic        last;
    int unsigned report_no;
    int unsigned pos;
  } sentence_byte_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic [IN_W-1:0] s_tdata = '0;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  char_t           m_tdata;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic            m_tlast;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [2:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  report_t        pending_reports[$];
  sentence_byte_t expected_bytes[$];
  sentence_byte_t want;
  char_t          talker_first = 8'd65;
  char_t          talker_second = 8'd73;
  int unsigned    reports_sent = 0;
  int unsigned    bytes_checked = 0;
  int unsigned    talker_writes = 0;
  int unsigned    mismatches = 0;
  int unsigned    idle_cycles = 0;
  int unsigned    burst_left = 0;
  int unsigned    gap_left = 0;
  int unsigned    stall_left = 0;
  int unsigned    stall_mode = 0;

  ais_position_report_encoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void encode_sentence(input report_t r);
    logic [167:0] payload;
    char_t        line [SENTENCE_BYTES];
    logic [5:0]   v;
    logic [7:0]   checksum;
    sentence_byte_t b;
    payload = {r.msg_kind, 2'b00, r.vessel_mmsi, r.status_code, r.turn_rate,
               r.ground_speed, r.pos_accuracy, r.longitude_pos, r.latitude_pos,
               r.ground_course, 9'h1FF, r.utc_second, 2'b00, 3'b000, 1'b0,
               2'b00, 3'd1, r.utc_hour, r.utc_minute, 2'b00};
    line[0] = "!";
    line[1] = talker_first;
    line[2] = talker_second;
    for (int i = 0; i < 11; i++) line[3 + i] = VDM_HEAD[8 * (10 - i) +: 8];
    for (int i = 0; i < 28; i++) begin
      v = payload[167 - 6 * i -: 6];
      line[14 + i] = {2'b00, v} + ((v < 6'd40) ? 8'd48 : 8'd56);
    end
    line[42] = ",";
    line[43] = "2";
    line[44] = "*";
    checksum = '0;
    for (int i = 1; i < 44; i++) checksum ^= line[i];
    line[45] = (checksum[7:4] < 4'd10) ? 8'h30 + checksum[7:4] : 8'h37 + checksum[7:4];
    line[46] = (checksum[3:0] < 4'd10) ? 8'h30 + checksum[3:0] : 8'h37 + checksum[3:0];
    line[47] = 8'h0D;
    line[48] = 8'h0A;
    for (int i = 0; i < SENTENCE_BYTES; i++) begin
      b.ch = line[i];
      b.last = (i == SENTENCE_BYTES - 1);
      b.report_no = reports_sent;
      b.pos = i;
      expected_bytes.push_back(b);
    end
  endfunction

  // biased toward zero, all ones, the sign / top bit and all ones below it
  function automatic logic [31:0] rand_bits(input int w);
    logic [31:0] all;
    all = (32'd1 << w) - 1;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return all;
      2: return 32'd1 << (w - 1);
      3: return all >> 1;
      default: return $urandom & all;
    endcase
  endfunction

  function automatic report_t random_report();
    report_t r;
    r.msg_kind      = $urandom_range(0, 1) ? 6'($urandom_range(1, 3)) : 6'(rand_bits(6));
    r.vessel_mmsi   = 30'(rand_bits(30));
    r.status_code   = 4'(rand_bits(4));
    r.turn_rate     = 8'(rand_bits(8));
    r.ground_speed  = 10'(rand_bits(10));
    r.pos_accuracy  = 1'($urandom_range(0, 1));
    r.longitude_pos = 28'(rand_bits(28));
    r.latitude_pos  = 27'(rand_bits(27));
    r.ground_course = 12'(rand_bits(12));
    r.utc_second    = 6'(rand_bits(6));
    r.utc_hour      = 5'(rand_bits(5));
    r.utc_minute    = 7'(rand_bits(7));
    return r;
  endfunction

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      REG_TALKER_FIRST:  talker_first = data[7:0];
      REG_TALKER_SECOND: talker_second = data[7:0];
      default: ;
    endcase
    talker_writes++;
  endtask

  task automatic wait_drained();
    while (pending_reports.size() != 0 || s_tvalid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // stream driver: bursts of reports separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        encode_sentence(report_t'(s_tdata));
        reports_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0 || pending_reports.size() == 0) begin
          s_tvalid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          s_tdata  <= pending_reports.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 6);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver backpressure: free, light, heavy or toggling stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 4) != 0);
      2: m_tready <= ($urandom_range(0, 2) == 0);
      default: m_tready <= ~m_tready;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sentence byte %02h last %0b", m_tdata, m_tlast);
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (m_tdata !== want.ch || m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report %0d byte %0d: expected %02h last %0b, got %02h last %0b",
                     want.report_no, want.pos, want.ch, want.last, m_tdata, m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    report_t r;
    char_t   tf;
    char_t   ts;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    r = '0;
    pending_reports.push_back(r);
    r = '1;
    pending_reports.push_back(r);
    r = report_t'({72{2'b01}});
    pending_reports.push_back(r);
    r = report_t'({72{2'b10}});
    pending_reports.push_back(r);
    r = '0;
    r.msg_kind = 6'd1;
    r.turn_rate = 8'h7F;
    r.longitude_pos = 28'h7FFFFFF;
    r.latitude_pos = 27'h3FFFFFF;
    r.ground_speed = 10'h3FF;
    r.ground_course = 12'hFFF;
    pending_reports.push_back(r);
    r = '0;
    r.msg_kind = 6'd2;
    r.turn_rate = 8'h80;
    r.longitude_pos = 28'h8000000;
    r.latitude_pos = 27'h4000000;
    r.status_code = 4'hF;
    pending_reports.push_back(r);
    r = '0;
    r.msg_kind = 6'd3;
    r.turn_rate = 8'hFF;
    r.longitude_pos = 28'hFFFFFFF;
    r.latitude_pos = 27'h7FFFFFF;
    r.pos_accuracy = 1'b1;
    pending_reports.push_back(r);
    // armoring alphabet boundary and top value
    r = '0;
    r.msg_kind = 6'd39;
    pending_reports.push_back(r);
    r.msg_kind = 6'd40;
    pending_reports.push_back(r);
    r.msg_kind = 6'd63;
    pending_reports.push_back(r);
    // second field: not available and special values
    for (int s = 60; s < 64; s++) begin
      r = '0;
      r.msg_kind = 6'd1;
      r.utc_second = 6'(s);
      pending_reports.push_back(r);
    end
    r = '0;
    r.msg_kind = 6'd1;
    r.utc_hour = 5'd31;
    r.utc_minute = 7'd127;
    pending_reports.push_back(r);
    r.utc_hour = 5'd23;
    r.utc_minute = 7'd59;
    r.vessel_mmsi = 30'h3FFFFFFF;
    pending_reports.push_back(r);
    wait_drained();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin tf = 8'h00; ts = 8'hFF; end
        1: begin tf = 8'hFF; ts = 8'h00; end
        3: begin tf = 8'h7F; ts = 8'h80; end
        5: begin tf = "A"; ts = "I"; end
        default: begin tf = 8'($urandom); ts = 8'($urandom); end
      endcase
      apb_write(REG_TALKER_FIRST, {24'($urandom), tf});
      apb_write(REG_TALKER_SECOND, {24'($urandom), ts});
      @(negedge clk);
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        pending_reports.push_back(random_report());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("%0d reports encoded into %0d checked sentence bytes", reports_sent,
             bytes_checked);
    $display("%0d talker register writes, %0d mismatches", talker_writes, mismatches);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
